>>> rtl/nctt_pkg.sv
// ----------------------------------------------------------------------------
// nctt_pkg
// Shared types, codes and helpers of the nearest-center track table.
// ----------------------------------------------------------------------------
package nctt_pkg;

  localparam int BOX_W   = 48;
  localparam int IDENT_W = 16;
  localparam int CTR_W   = 14;  // doubled center: 2*edge + size
  localparam int D2_W    = 29;  // sum of two squared doubled offsets
  localparam int NUM_W   = 6;
  localparam logic [NUM_W-1:0] NUM_MAX = 6'd63;
  localparam logic [4:0] CREATE_LIMIT = 5'd30;

  typedef enum logic [1:0] {
    OP_FRAME_START = 2'd0,
    OP_DETECT      = 2'd1,
    OP_FRAME_END   = 2'd2,
    OP_LOOKUP      = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    KIND_MATCHED       = 3'd0,
    KIND_PENDING       = 3'd1,
    KIND_CREATED       = 3'd2,
    KIND_TABLE_FULL    = 3'd3,
    KIND_OVERFLOW      = 3'd4,
    KIND_FRAME_STARTED = 3'd5,
    KIND_FRAME_DONE    = 3'd6,
    KIND_LOOKUP        = 3'd7
  } kind_e;

  typedef enum logic [1:0] {
    CFG_DISTANCE_LIMIT = 2'd0,
    CFG_MISSED_LIMIT   = 2'd1,
    CFG_TRACK_CAPACITY = 2'd2,
    CFG_UNUSED         = 2'd3
  } cfg_e;

  // per-cell commands; a removal sweep raises remove and rank_dec together
  typedef struct packed {
    logic age;
    logic match_upd;
    logic create;
    logic remove;
    logic rank_dec;
  } cell_ctl_t;

  // best candidate handed along the row
  typedef struct packed {
    logic               valid;
    logic [D2_W-1:0]    d2;
    logic [IDENT_W-1:0] ident;
    logic [BOX_W-1:0]   box;
  } chain_t;

  function automatic logic [CTR_W-1:0] centre2(input logic [11:0] pos,
                                               input logic [11:0] size);
    centre2 = {1'b0, pos, 1'b0} + {2'b00, size};
  endfunction

endpackage

>>> rtl/nearest_center_track_table.sv
// ----------------------------------------------------------------------------
// nearest_center_track_table
// Track table that associates detections with the nearest active track.
// ----------------------------------------------------------------------------
// Each track lives in one cell of a row of MAX_TRACKS cells. A detection or a
// lookup first computes the squared distances (every cell at once), then the
// best candidate walks the row one cell per cycle, and the result is posted
// from the result register. frame_start ages all cells and posts its result.
// frame_end reads each pending detection from the buffer, then creates a track
// for it; once the buffer runs out, or with table_full when no room is left, it
// sweeps the row once to remove inactive tracks, then posts frame_done. A
// stalled result output holds each step that posts a result.
// One request is worked at a time; the result register lets the next request
// in while an earlier result still waits on the output. Config writes are
// always taken and must only come while the block is idle.
// ----------------------------------------------------------------------------
module nearest_center_track_table #(
  parameter int MAX_TRACKS  = 16,
  parameter int MAX_PENDING = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [11:0] box_left_i,
  input  logic [11:0] box_top_i,
  input  logic [11:0] box_width_i,
  input  logic [11:0] box_height_i,
  input  logic [15:0] query_id_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  kind_o,
  output logic [15:0] track_ident_o,
  output logic [5:0]  detection_number_o,
  output logic        found_o,
  output logic [11:0] out_left_o,
  output logic [11:0] out_top_o,
  output logic [11:0] out_width_o,
  output logic [11:0] out_height_o,
  output logic [4:0]  expired_count_o,
  output logic        last_o,
  // config write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i
);
  import nctt_pkg::*;

  localparam int RW  = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int UW  = $clog2(MAX_TRACKS + 1);
  localparam int AW  = (MAX_PENDING > 1) ? $clog2(MAX_PENDING) : 1;
  localparam int PCW = $clog2(MAX_PENDING + 1);
  localparam int PW  = NUM_W + BOX_W;

  typedef enum logic [3:0] {
    S_IDLE, S_FS, S_DIST, S_CHAIN, S_RES, S_FE_RD, S_FE_CR, S_RM, S_DONE
  } state_e;

  // config registers
  logic [11:0] dist_limit_q;
  logic [7:0]  missed_limit_q;
  logic [4:0]  capacity_q;

  state_e             state_q, state_d;
  logic [1:0]         op_q;
  logic [BOX_W-1:0]   det_box_q;
  logic [IDENT_W-1:0] query_q;
  logic [NUM_W-1:0]   num_q;
  logic [CTR_W-1:0]   det_cx_q, det_cy_q;
  logic [D2_W-1:0]    limit2_q;
  logic [NUM_W-1:0]   fdet_q, fdet_d;
  logic [PCW-1:0]     pend_q, pend_d, p_q, p_d;
  logic [4:0]         created_q, created_d;
  logic [UW-1:0]      used_q, used_d, cnt_q, cnt_d;
  logic [IDENT_W-1:0] next_q, next_d;

  // result register
  logic               out_valid_q;
  logic [2:0]         kind_q;
  logic [IDENT_W-1:0] ident_q;
  logic [NUM_W-1:0]   onum_q;
  logic               found_q;
  logic [BOX_W-1:0]   obox_q;
  logic [4:0]         exp_q;
  logic               last_q;

  logic               out_load;
  kind_e              o_kind;
  logic [IDENT_W-1:0] o_ident;
  logic [NUM_W-1:0]   o_num;
  logic               o_found;
  logic [BOX_W-1:0]   o_box;
  logic [4:0]         o_exp;
  logic               o_last;

  logic in_acc, out_free, can_create, rem;
  logic [RW-1:0] free_idx, sweep_idx;
  logic [6:0]    exp_cnt;

  // cell row
  cell_ctl_t          ctl      [MAX_TRACKS];
  logic               used_w   [MAX_TRACKS];
  logic               active_w [MAX_TRACKS];
  logic [RW-1:0]      rank_w   [MAX_TRACKS];
  logic               expire_w [MAX_TRACKS];
  chain_t             chain_w  [MAX_TRACKS+1];
  logic [RW-1:0]      crank_w  [MAX_TRACKS+1];
  logic [RW-1:0]      cidx_w   [MAX_TRACKS+1];
  logic [BOX_W-1:0]   wr_box;
  logic [RW-1:0]      dec_rank;
  chain_t             win;
  logic [RW-1:0]      win_idx;

  // pending buffer
  logic             ram_we, ram_re;
  logic [PW-1:0]    ram_rdata;
  logic [NUM_W-1:0] ram_num;
  logic [BOX_W-1:0] ram_box;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_limit_q   <= 12'd100;
      missed_limit_q <= 8'd10;
      capacity_q     <= 5'd16;
    end else if (cfg_valid_i) begin
      case (cfg_e'(cfg_index_i))
        CFG_DISTANCE_LIMIT: dist_limit_q   <= cfg_data_i;
        CFG_MISSED_LIMIT:   missed_limit_q <= cfg_data_i[7:0];
        CFG_TRACK_CAPACITY: capacity_q     <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  assign chain_w[0] = '0;
  assign crank_w[0] = '0;
  assign cidx_w[0]  = '0;

  for (genvar g = 0; g < MAX_TRACKS; g++) begin : g_cell
    nctt_cell #(
      .RANK_W   (RW),
      .CELL_IDX (g)
    ) u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .ctl_i          (ctl[g]),
      .missed_limit_i (missed_limit_q),
      .det_cx_i       (det_cx_q),
      .det_cy_i       (det_cy_q),
      .limit2_i       (limit2_q),
      .lookup_i       (op_q == OP_LOOKUP),
      .query_i        (query_q),
      .wr_box_i       (wr_box),
      .wr_ident_i     (next_q),
      .wr_rank_i      (used_q[RW-1:0]),
      .dec_rank_i     (dec_rank),
      .chain_i        (chain_w[g]),
      .chain_rank_i   (crank_w[g]),
      .chain_idx_i    (cidx_w[g]),
      .chain_o        (chain_w[g+1]),
      .chain_rank_o   (crank_w[g+1]),
      .chain_idx_o    (cidx_w[g+1]),
      .used_o         (used_w[g]),
      .active_o       (active_w[g]),
      .rank_o         (rank_w[g]),
      .expire_o       (expire_w[g])
    );
  end

  assign win     = chain_w[MAX_TRACKS];
  assign win_idx = cidx_w[MAX_TRACKS];

  nctt_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_PENDING)
  ) u_pend_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (pend_q[AW-1:0]),
    .wdata_i ({num_q, det_box_q}),
    .re_i    (ram_re),
    .raddr_i (p_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );
  assign ram_num = ram_rdata[PW-1:BOX_W];
  assign ram_box = ram_rdata[BOX_W-1:0];

  // tracks expiring on this frame_start
  always_comb begin
    exp_cnt = '0;
    for (int i = 0; i < MAX_TRACKS; i++) begin
      exp_cnt = exp_cnt + 7'(expire_w[i]);
    end
  end

  // lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = MAX_TRACKS - 1; i >= 0; i--) begin
      if (!used_w[i]) free_idx = RW'(i);
    end
  end

  // room check: capacity register clipped to the row length, and at most CREATE_LIMIT creations per frame_end
  assign can_create = (8'(used_q) < 8'(capacity_q)) && (8'(used_q) < 8'(MAX_TRACKS)) &&
                      (created_q < CREATE_LIMIT);

  assign sweep_idx = cnt_q[RW-1:0];
  assign rem       = used_w[sweep_idx] && !active_w[sweep_idx];

  always_comb begin
    state_d   = state_q;
    fdet_d    = fdet_q;
    pend_d    = pend_q;
    p_d       = p_q;
    created_d = created_q;
    used_d    = used_q;
    cnt_d     = cnt_q;
    next_d    = next_q;
    for (int i = 0; i < MAX_TRACKS; i++) ctl[i] = '0;
    dec_rank  = '0;
    wr_box    = det_box_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    out_load  = 1'b0;
    o_kind    = KIND_MATCHED;
    o_ident   = '0;
    o_num     = '0;
    o_found   = 1'b0;
    o_box     = '0;
    o_exp     = '0;
    o_last    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (op_e'(operation_i))
            OP_FRAME_START: state_d = S_FS;
            OP_DETECT: begin
              if (fdet_q < NUM_MAX) fdet_d = fdet_q + NUM_W'(1);
              state_d = S_DIST;
            end
            OP_LOOKUP: state_d = S_DIST;
            OP_FRAME_END: begin
              p_d       = '0;
              created_d = '0;
              state_d   = S_FE_RD;
            end
            default: ;
          endcase
        end
      end

      S_FS: begin
        if (out_free) begin
          for (int i = 0; i < MAX_TRACKS; i++) ctl[i].age = 1'b1;
          out_load = 1'b1;
          o_kind   = KIND_FRAME_STARTED;
          o_exp    = exp_cnt[4:0];
          o_last   = 1'b1;
          pend_d   = '0;
          fdet_d   = '0;
          state_d  = S_IDLE;
        end
      end

      S_DIST: begin
        cnt_d   = '0;
        state_d = S_CHAIN;
      end

      // candidate walks the row
      S_CHAIN: begin
        cnt_d = cnt_q + UW'(1);
        if (cnt_q == UW'(MAX_TRACKS - 1)) state_d = S_RES;
      end

      S_RES: begin
        if (out_free) begin
          out_load = 1'b1;
          o_last   = 1'b1;
          state_d  = S_IDLE;
          if (op_q == OP_LOOKUP) begin
            o_kind  = KIND_LOOKUP;
            o_ident = query_q;
            o_found = win.valid;
            o_box   = win.valid ? win.box : '0;
          end else begin
            o_num = num_q;
            if (win.valid) begin
              ctl[win_idx].match_upd = 1'b1;
              o_kind  = KIND_MATCHED;
              o_ident = win.ident;
            end else if (pend_q < PCW'(MAX_PENDING)) begin
              ram_we = 1'b1;
              pend_d = pend_q + PCW'(1);
              o_kind = KIND_PENDING;
            end else begin
              o_kind = KIND_OVERFLOW;
            end
          end
        end
      end

      S_FE_RD: begin
        if (p_q < pend_q) begin
          ram_re  = 1'b1;
          state_d = S_FE_CR;
        end else begin
          cnt_d   = '0;
          state_d = S_RM;
        end
      end

      S_FE_CR: begin
        if (out_free) begin
          out_load = 1'b1;
          o_num    = ram_num;
          if (can_create) begin
            ctl[free_idx].create = 1'b1;
            wr_box    = ram_box;
            o_kind    = KIND_CREATED;
            o_ident   = next_q;
            next_d    = next_q + IDENT_W'(1);
            used_d    = used_q + UW'(1);
            created_d = created_q + 5'd1;
            p_d       = p_q + PCW'(1);
            state_d   = S_FE_RD;
          end else begin
            o_kind  = KIND_TABLE_FULL;
            cnt_d   = '0;
            state_d = S_RM;
          end
        end
      end

      // one slot per cycle: drop it if used but inactive and close the rank gap
      S_RM: begin
        for (int i = 0; i < MAX_TRACKS; i++) ctl[i].rank_dec = rem;
        ctl[sweep_idx].remove = rem;
        dec_rank = rank_w[sweep_idx];
        if (rem) used_d = used_q - UW'(1);
        cnt_d = cnt_q + UW'(1);
        if (cnt_q == UW'(MAX_TRACKS - 1)) state_d = S_DONE;
      end

      S_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          o_kind   = KIND_FRAME_DONE;
          o_last   = 1'b1;
          pend_d   = '0;
          fdet_d   = '0;
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fdet_q      <= '0;
      pend_q      <= '0;
      p_q         <= '0;
      created_q   <= '0;
      used_q      <= '0;
      cnt_q       <= '0;
      next_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fdet_q    <= fdet_d;
      pend_q    <= pend_d;
      p_q       <= p_d;
      created_q <= created_d;
      used_q    <= used_d;
      cnt_q     <= cnt_d;
      next_q    <= next_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q      <= operation_i;
      det_box_q <= {box_height_i, box_width_i, box_top_i, box_left_i};
      query_q   <= query_id_i;
      num_q     <= fdet_q;
      det_cx_q  <= centre2(box_left_i, box_width_i);
      det_cy_q  <= centre2(box_top_i, box_height_i);
      // 4 * limit^2, full 24-bit square
      limit2_q  <= D2_W'({24'(dist_limit_q) * 24'(dist_limit_q), 2'b00});
    end
    if (out_load) begin
      kind_q  <= o_kind;
      ident_q <= o_ident;
      onum_q  <= o_num;
      found_q <= o_found;
      obox_q  <= o_box;
      exp_q   <= o_exp;
      last_q  <= o_last;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign kind_o             = kind_q;
  assign track_ident_o      = ident_q;
  assign detection_number_o = onum_q;
  assign found_o            = found_q;
  assign out_left_o         = obox_q[11:0];
  assign out_top_o          = obox_q[23:12];
  assign out_width_o        = obox_q[35:24];
  assign out_height_o       = obox_q[47:36];
  assign expired_count_o    = exp_q;
  assign last_o             = last_q;

endmodule

>>> rtl/nctt_ram.sv
// ----------------------------------------------------------------------------
// nctt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nctt_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/nctt_cell.sv
// ----------------------------------------------------------------------------
// nctt_cell
// One track slot: holds its state, squares its distance to the current
// detection and merges itself into the best candidate passed from its left.
// ----------------------------------------------------------------------------
module nctt_cell #(
  parameter int RANK_W   = 4,
  parameter int CELL_IDX = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  nctt_pkg::cell_ctl_t           ctl_i,
  input  logic [7:0]                    missed_limit_i,
  input  logic [nctt_pkg::CTR_W-1:0]    det_cx_i,
  input  logic [nctt_pkg::CTR_W-1:0]    det_cy_i,
  input  logic [nctt_pkg::D2_W-1:0]     limit2_i,
  input  logic                          lookup_i,
  input  logic [nctt_pkg::IDENT_W-1:0]  query_i,
  input  logic [nctt_pkg::BOX_W-1:0]    wr_box_i,
  input  logic [nctt_pkg::IDENT_W-1:0]  wr_ident_i,
  input  logic [RANK_W-1:0]             wr_rank_i,
  input  logic [RANK_W-1:0]             dec_rank_i,
  input  nctt_pkg::chain_t              chain_i,
  input  logic [RANK_W-1:0]             chain_rank_i,
  input  logic [RANK_W-1:0]             chain_idx_i,
  output nctt_pkg::chain_t              chain_o,
  output logic [RANK_W-1:0]             chain_rank_o,
  output logic [RANK_W-1:0]             chain_idx_o,
  output logic                          used_o,
  output logic                          active_o,
  output logic [RANK_W-1:0]             rank_o,
  output logic                          expire_o
);
  import nctt_pkg::*;

  logic                 used_q, active_q;
  logic [IDENT_W-1:0]   ident_q;
  logic [BOX_W-1:0]     box_q;
  logic [7:0]           missed_q;
  logic [RANK_W-1:0]    rank_q;
  logic [D2_W-1:0]      d2_q;
  chain_t               chain_q;
  logic [RANK_W-1:0]    chain_rank_q, chain_idx_q;

  logic [8:0]           missed_inc;
  logic signed [14:0]   dx, dy;
  logic signed [29:0]   sqx, sqy;
  logic [D2_W-1:0]      d2_d;
  logic [D2_W-1:0]      key;
  logic                 elig, take;

  assign missed_inc = {1'b0, missed_q} + 9'd1;
  assign expire_o   = used_q && active_q && (missed_inc > {1'b0, missed_limit_i});

  // squared doubled center offset
  assign dx   = $signed({1'b0, det_cx_i}) - $signed({1'b0, centre2(box_q[11:0], box_q[35:24])});
  assign dy   = $signed({1'b0, det_cy_i}) - $signed({1'b0, centre2(box_q[23:12], box_q[47:36])});
  assign sqx  = dx * dx;
  assign sqy  = dy * dy;
  assign d2_d = {1'b0, sqx[D2_W-2:0]} + {1'b0, sqy[D2_W-2:0]};

  // merge own entry with the candidate from the left; ties go to lower rank
  assign elig = used_q && active_q &&
                (lookup_i ? (ident_q == query_i) : (d2_q < limit2_i));
  assign key  = lookup_i ? '0 : d2_q;
  assign take = elig && (!chain_i.valid || (key < chain_i.d2) ||
                         ((key == chain_i.d2) && (rank_q < chain_rank_i)));

  always_ff @(posedge clk_i) begin
    d2_q <= d2_d;
    if (take) begin
      chain_q      <= '{valid: 1'b1, d2: key, ident: ident_q, box: box_q};
      chain_rank_q <= rank_q;
      chain_idx_q  <= RANK_W'(CELL_IDX);
    end else begin
      chain_q      <= chain_i;
      chain_rank_q <= chain_rank_i;
      chain_idx_q  <= chain_idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q   <= 1'b0;
      active_q <= 1'b0;
    end else begin
      if (ctl_i.age && used_q && active_q && expire_o) begin
        active_q <= 1'b0;
      end
      if (ctl_i.match_upd || ctl_i.create) begin
        active_q <= 1'b1;
      end
      if (ctl_i.create) begin
        used_q <= 1'b1;
      end
      if (ctl_i.remove) begin
        used_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.age && used_q && active_q) begin
      missed_q <= missed_inc[8] ? 8'hFF : missed_inc[7:0];
    end
    if (ctl_i.match_upd || ctl_i.create) begin
      box_q    <= wr_box_i;
      missed_q <= '0;
    end
    if (ctl_i.create) begin
      ident_q <= wr_ident_i;
      rank_q  <= wr_rank_i;
    end
    if (ctl_i.rank_dec && used_q && (rank_q > dec_rank_i)) begin
      rank_q <= rank_q - RANK_W'(1);
    end
  end

  assign chain_o      = chain_q;
  assign chain_rank_o = chain_rank_q;
  assign chain_idx_o  = chain_idx_q;
  assign used_o       = used_q;
  assign active_o     = active_q;
  assign rank_o       = rank_q;

endmodule

>>> rtl/nctt_checker.sv
// ----------------------------------------------------------------------------
// nctt_checker
// Port-level checks for the track table, bound to the top level.
// ----------------------------------------------------------------------------
module nctt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  kind_o,
  input logic        found_o,
  input logic [11:0] out_left_o,
  input logic        last_o
);
  import nctt_pkg::*;

  // result held until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before accept");

  // in_ready_o is low the cycle after a request is taken
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while busy");

  // created and table_full are never the final result of a frame_end
  a_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_CREATED || kind_o == KIND_TABLE_FULL) |-> !last_o)
    else $error("frame_end result marked last");

  // only a lookup hit carries a box
  a_found_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != KIND_LOOKUP |-> !found_o && out_left_o == 12'd0)
    else $error("box on non-lookup result");

endmodule

bind nearest_center_track_table nctt_checker u_nctt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .kind_o      (kind_o),
  .found_o     (found_o),
  .out_left_o  (out_left_o),
  .last_o      (last_o)
);
